FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Clocked, reset-gated property check reporting through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge while rst_n is high.
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`endif

FILE: hdl/mme_pkg.sv
// Package for the modular exponentiation block.
// Constants, register indexes and the multiplier status type; no dependencies.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int unsigned FIELD_W      = 64;
  localparam int unsigned NUM_BITS_DEF = 64;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [FIELD_W-1:0] RESET_MODULUS   = FIELD_W'(71);
  localparam logic [FIELD_W-1:0] RESET_GENERATOR = FIELD_W'(61);

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = CFG_IDX_W'(1);

  localparam logic KIND_PUBLIC = 1'b0;
  localparam logic KIND_SHARED = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

FILE: hdl/mme_cell.sv
// One cell of the multiplier operand chain: holds one bit, loads or
// passes its bit to the next cell up. Uses nothing else.
`timescale 1ns / 1ps

module mme_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic load_bit_i,
  input  logic shift_i,
  input  logic shift_in_i,
  output logic bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

FILE: hdl/mme_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle,
// b held in a chain of mme_cell. Depends on mme_pkg and mme_cell.
`timescale 1ns / 1ps

module mme_mulmod #(
  parameter int unsigned NUM_BITS = mme_pkg::NUM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_BITS-1:0]  a_i,
  input  logic [NUM_BITS-1:0]  b_i,
  input  logic [NUM_BITS-1:0]  m_i,
  output logic [NUM_BITS-1:0]  prod_o,
  output mme_pkg::mul_status_t status_o
);
  import mme_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] acc_q, acc_d, a_q, m_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [NUM_BITS-1:0] chain;
  logic [NUM_BITS:0]   s1, s2;
  logic [NUM_BITS-1:0] r1, r2;

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
    mme_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (start_i),
      .load_bit_i (b_i[i]),
      .shift_i    (busy_q),
      .shift_in_i ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
      .bit_o      (chain[i])
    );
  end

  always_comb begin
    s1 = {1'b0, acc_q} + {1'b0, acc_q};
    r1 = (s1 >= {1'b0, m_q}) ? NUM_BITS'(s1 - {1'b0, m_q}) : s1[NUM_BITS-1:0];
    s2 = {1'b0, r1} + {1'b0, a_q};
    r2 = (s2 >= {1'b0, m_q}) ? NUM_BITS'(s2 - {1'b0, m_q}) : s2[NUM_BITS-1:0];

    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      cnt_d  = CNT_W'(NUM_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = chain[NUM_BITS-1] ? r2 : r1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      m_q <= m_i;
    end
  end

  assign prod_o          = acc_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

FILE: hdl/modular_exponentiation.sv
// Base reduction then square-and-multiply over NUM_BITS exponent bits, each
// modular product computed in the bit-serial multiplier; a modulus below two
// gives zero without any product.
// One beat at a time. Reset (async, active low) clears control and loads
// modulus 71 and generator 61.
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int unsigned NUM_BITS = mme_pkg::NUM_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mme_pkg::FIELD_W-1:0]          cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // peer_key [63:0], secret_exponent [127:64]
  input  logic [2*mme_pkg::FIELD_W-1:0]        s_axis_tdata_i,
  // kind [0]
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // power_result [63:0]
  output logic [mme_pkg::FIELD_W-1:0]          m_axis_tdata_o
);
  import mme_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(NUM_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_SQ, ST_MUL, ST_FIN
  } state_e;

  state_e              state_q;
  logic [FIELD_W-1:0]  modulus_q, generator_q;
  logic [NUM_BITS-1:0] m_q, base_q, exp_q, acc_q, op_a_q, op_b_q;
  logic [CNT_W-1:0]    ecnt_q;
  logic                start_q, start_d;
  logic                out_valid_q, out_valid_d;
  logic [NUM_BITS-1:0] out_data_q;
  logic [NUM_BITS-1:0] prod;
  mul_status_t         mul_st;
  logic                in_fire;
  logic [NUM_BITS-1:0] in_m;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_m    = modulus_q[NUM_BITS-1:0];
  assign s_axis_tready_o = (state_q == ST_IDLE);

  assign start_d = (in_fire && !(in_m < NUM_BITS'(2))) ||
                   (state_q == ST_RED && mul_st.done) ||
                   ((state_q == ST_SQ || state_q == ST_MUL) && mul_st.done &&
                    ((state_q == ST_SQ && exp_q[NUM_BITS-1]) || ecnt_q != '0));

  assign out_valid_d = (state_q == ST_FIN && (!out_valid_q || m_axis_tready_i)) ||
                       (out_valid_q && !m_axis_tready_i);

  mme_mulmod #(.NUM_BITS(NUM_BITS)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .a_i      (op_a_q),
    .b_i      (op_b_q),
    .m_i      (m_q),
    .prod_o   (prod),
    .status_o (mul_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= RESET_MODULUS;
      generator_q <= RESET_GENERATOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODULUS:   modulus_q   <= cfg_data_i;
        REG_GENERATOR: generator_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ecnt_q      <= '0;
    end else begin
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            m_q    <= in_m;
            exp_q  <= s_axis_tdata_i[FIELD_W +: NUM_BITS];
            ecnt_q <= CNT_W'(NUM_BITS - 1);
            if (in_m < NUM_BITS'(2)) begin
              acc_q   <= '0;
              state_q <= ST_FIN;
            end else begin
              op_a_q  <= NUM_BITS'(1);
              op_b_q  <= (s_axis_tuser_i == KIND_SHARED) ?
                         s_axis_tdata_i[NUM_BITS-1:0] : generator_q[NUM_BITS-1:0];
              state_q <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (mul_st.done) begin
            base_q  <= prod;
            op_a_q  <= NUM_BITS'(1);
            op_b_q  <= NUM_BITS'(1);
            state_q <= ST_SQ;
          end
        end
        ST_SQ, ST_MUL: begin
          if (mul_st.done) begin
            if (state_q == ST_SQ && exp_q[NUM_BITS-1]) begin
              op_a_q  <= prod;
              op_b_q  <= base_q;
              state_q <= ST_MUL;
            end else if (ecnt_q == '0) begin
              acc_q   <= prod;
              state_q <= ST_FIN;
            end else begin
              exp_q   <= exp_q << 1;
              ecnt_q  <= ecnt_q - CNT_W'(1);
              op_a_q  <= prod;
              op_b_q  <= prod;
              state_q <= ST_SQ;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = FIELD_W'(out_data_q);

  `MME_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !s_axis_tready_o, "accepted while busy")
  `MME_ASSERT(a_done_in_run, clk_i, rst_ni, mul_st.done |-> (state_q == ST_RED || state_q == ST_SQ || state_q == ST_MUL), "multiplier done outside a run")
  `MME_ASSERT(a_prod_reduced, clk_i, rst_ni, (mul_st.done && state_q != ST_IDLE) |-> (prod < m_q), "product not reduced")

endmodule
